// ===== rtl/pics_pkg.sv =====
package pics_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_OUT_LOW       = 3'd3,
    REG_OUT_HIGH      = 3'd4,
    REG_WINDUP_MARGIN = 3'd5
  } reg_idx_e;

  localparam int unsigned UcAddrW = 4;

  // ALU operations
  typedef enum logic [2:0] {
    ALU_ADD,    // saturating a + b
    ALU_SUB,    // saturating a - b
    ALU_PASS,   // a
    ALU_QSC,    // product register / 2^16, toward zero, saturated
    ALU_CLAMP   // a clamped to the selected bounds
  } alu_op_e;

  typedef enum logic [2:0] {
    A_TARGET,
    A_LO,
    A_HI,
    A_T,
    A_P,
    A_PRESET
  } a_sel_e;

  typedef enum logic [2:0] {
    B_MEAS,
    B_MARGIN,
    B_I,
    B_INTEG,
    B_P
  } b_sel_e;

  typedef enum logic {
    BND_OUT,
    BND_WIDE
  } bnd_sel_e;

  typedef enum logic [3:0] {
    D_ERR,
    D_WLO,
    D_WHI,
    D_T,
    D_P,
    D_I,
    D_INTEG,
    D_HELD
  } dst_sel_e;

  typedef enum logic {
    MA_ERR,
    MA_T
  } mul_a_e;

  typedef enum logic [1:0] {
    MB_KP,
    MB_KI,
    MB_TS
  } mul_b_e;

  typedef struct packed {
    alu_op_e              alu;
    a_sel_e               a;
    b_sel_e               b;
    bnd_sel_e             bnd;
    dst_sel_e             dst;
    logic                 mul_en;
    mul_a_e               mul_a;
    mul_b_e               mul_b;
    logic                 br_rst;   // branch when the item is a reset item
    logic                 done;     // last step, hand result to output
    logic [UcAddrW-1:0]   br_tgt;
  } ucode_t;

  localparam logic [UcAddrW-1:0] UcRstEntry = 4'd12;
  localparam logic [UcAddrW-1:0] UcLast     = 4'd14;

  function automatic ucode_t uc(input alu_op_e alu, input a_sel_e a, input b_sel_e b,
                                input bnd_sel_e bnd, input dst_sel_e dst,
                                input logic mul_en, input mul_a_e ma, input mul_b_e mb,
                                input logic br_rst, input logic done);
    ucode_t w;
    w.alu    = alu;
    w.a      = a;
    w.b      = b;
    w.bnd    = bnd;
    w.dst    = dst;
    w.mul_en = mul_en;
    w.mul_a  = ma;
    w.mul_b  = mb;
    w.br_rst = br_rst;
    w.done   = done;
    w.br_tgt = UcRstEntry;
    return w;
  endfunction

  // Control store. Steps 0..6 are shared, 7..11 finish an update, 12..14 a reset.
  function automatic ucode_t uc_rom(input logic [UcAddrW-1:0] addr);
    ucode_t w;
    case (addr)
      4'd0:  w = uc(ALU_SUB,   A_TARGET, B_MEAS,   BND_OUT,  D_ERR,   1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd1:  w = uc(ALU_SUB,   A_LO,     B_MARGIN, BND_OUT,  D_WLO,   1'b1, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd2:  w = uc(ALU_QSC,   A_T,      B_P,      BND_OUT,  D_T,     1'b1, MA_ERR, MB_KI,
                    1'b0, 1'b0);
      4'd3:  w = uc(ALU_CLAMP, A_T,      B_P,      BND_OUT,  D_P,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd4:  w = uc(ALU_QSC,   A_T,      B_P,      BND_OUT,  D_T,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd5:  w = uc(ALU_ADD,   A_HI,     B_MARGIN, BND_OUT,  D_WHI,   1'b1, MA_T,   MB_TS,
                    1'b0, 1'b0);
      4'd6:  w = uc(ALU_QSC,   A_T,      B_P,      BND_OUT,  D_I,     1'b0, MA_ERR, MB_KP,
                    1'b1, 1'b0);
      4'd7:  w = uc(ALU_ADD,   A_P,      B_I,      BND_OUT,  D_T,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd8:  w = uc(ALU_ADD,   A_T,      B_INTEG,  BND_OUT,  D_T,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd9:  w = uc(ALU_CLAMP, A_T,      B_P,      BND_WIDE, D_T,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd10: w = uc(ALU_CLAMP, A_T,      B_P,      BND_OUT,  D_HELD,  1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd11: w = uc(ALU_SUB,   A_T,      B_P,      BND_OUT,  D_INTEG, 1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b1);
      4'd12: w = uc(ALU_PASS,  A_PRESET, B_P,      BND_OUT,  D_HELD,  1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd13: w = uc(ALU_SUB,   A_PRESET, B_I,      BND_OUT,  D_T,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b0);
      4'd14: w = uc(ALU_SUB,   A_T,      B_P,      BND_OUT,  D_INTEG, 1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b1);
      default: w = uc(ALU_PASS, A_T,     B_P,      BND_OUT,  D_T,     1'b0, MA_ERR, MB_KP,
                    1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pi_controller_saturated.sv =====
// Saturated PI controller with anti-windup, signed Q16.16 throughout. An update
// item forms err = target - measured, a proportional term err*kp clamped to
// [out_low, out_high], and an integral increment err*ki*ts; it adds both and the
// integrator, clamps the sum to the output range widened by windup_margin, drives
// that sum clamped to the output range and keeps (sum - proportional term) as the
// integrator. A reset item (operation = 1) drives preset_output and primes the
// integrator so that an update with the same error reproduces the preset.
// Products are exact 64-bit, divided by 2^16 toward zero; every sum and product
// saturates to 32 bits. One item is worked at a time by a microcoded sequencer
// over a single 32x32 multiplier and a single saturating ALU, which does one
// operation per step. A finished result sits in an output register, so the next
// item is taken while it waits; the sequencer holds on its last step only if the
// previous result has still not been taken. The user must write configuration
// through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle; the block
// itself does not enforce it. Unknown indexes are ignored.
module pi_controller_saturated (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] measured_i,
  input  logic [31:0] target_i,
  input  logic [31:0] preset_output_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] drive_o
);
  import pics_pkg::*;

  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  // Saturate a 33-bit sum to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) r = v[31:0];
    else if (v[32])     r = S32Min;
    else                r = S32Max;
    return r;
  endfunction

  // Product / 2^16 truncated toward zero, saturated to 32 bits.
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic               rnd;
    logic signed [47:0] s;
    logic signed [31:0] r;
    rnd = p[63] && (p[15:0] != 16'd0);
    s   = $signed(p[63:16]) + $signed({47'd0, rnd});
    if ((&s[47:31]) || !(|s[47:31])) r = s[31:0];
    else if (s[47])                  r = S32Min;
    else                             r = S32Max;
    return r;
  endfunction

  // Raise to lo, then lower to hi: inverted bounds give hi.
  function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                               input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v > hi || lo > hi) r = hi;
    else if (v < lo)       r = lo;
    else                   r = v;
    return r;
  endfunction

  // configuration
  logic signed [31:0] kp_q, ki_q, out_low_q, out_high_q;
  logic        [30:0] ts_q, margin_q;

  // sequencer
  logic               busy_q;
  logic [UcAddrW-1:0] pc_q;
  ucode_t             uc_w;
  logic               step_go;
  logic               in_xfer;

  // architectural state and result register
  logic signed [31:0] integ_q, held_q, drive_q;
  logic               out_valid_q;

  // operand latches and scratch
  logic               op_q;
  logic signed [31:0] meas_q, target_q, preset_q;
  logic signed [31:0] err_q, wlo_q, whi_q, t_q, p_q, i_q;
  logic signed [63:0] prod_q;

  logic signed [31:0] a_val, b_val, bnd_lo, bnd_hi, alu_res;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_res;

  assign uc_w       = uc_rom(pc_q);
  assign in_xfer    = in_valid_i && !busy_q;
  // hold on the last step while the previous result is still unclaimed
  assign step_go    = busy_q && !(uc_w.done && out_valid_q && out_stall_i);
  assign in_stall_o = busy_q;
  assign out_valid_o = out_valid_q;
  assign drive_o    = drive_q;

  always_comb begin
    case (uc_w.a)
      A_TARGET: a_val = target_q;
      A_LO:     a_val = out_low_q;
      A_HI:     a_val = out_high_q;
      A_T:      a_val = t_q;
      A_P:      a_val = p_q;
      A_PRESET: a_val = preset_q;
      default:  a_val = t_q;
    endcase
    case (uc_w.b)
      B_MEAS:   b_val = meas_q;
      B_MARGIN: b_val = $signed({1'b0, margin_q});
      B_I:      b_val = i_q;
      B_INTEG:  b_val = integ_q;
      B_P:      b_val = p_q;
      default:  b_val = p_q;
    endcase
    case (uc_w.bnd)
      BND_WIDE: begin
        bnd_lo = wlo_q;
        bnd_hi = whi_q;
      end
      default: begin
        bnd_lo = out_low_q;
        bnd_hi = out_high_q;
      end
    endcase
  end

  always_comb begin
    case (uc_w.alu)
      ALU_ADD:   alu_res = sat33({a_val[31], a_val} + {b_val[31], b_val});
      ALU_SUB:   alu_res = sat33({a_val[31], a_val} - {b_val[31], b_val});
      ALU_PASS:  alu_res = a_val;
      ALU_QSC:   alu_res = qscale(prod_q);
      ALU_CLAMP: alu_res = clamp(a_val, bnd_lo, bnd_hi);
      default:   alu_res = a_val;
    endcase
  end

  // shared multiplier, one product per step, registered
  always_comb begin
    case (uc_w.mul_a)
      MA_T:    mul_a = t_q;
      default: mul_a = err_q;
    endcase
    case (uc_w.mul_b)
      MB_KI:   mul_b = ki_q;
      MB_TS:   mul_b = $signed({1'b0, ts_q});
      default: mul_b = kp_q;
    endcase
  end
  assign mul_res = mul_a * mul_b;

  // control, configuration and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      kp_q        <= 32'sd65536;
      ki_q        <= 32'sd0;
      ts_q        <= 31'd65536;
      out_low_q   <= -32'sd65536;
      out_high_q  <= 32'sd65536;
      margin_q    <= 31'd0;
      integ_q     <= 32'sd0;
      held_q      <= 32'sd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN:     kp_q       <= cfg_data_i;
          REG_INTEG_GAIN:    ki_q       <= cfg_data_i;
          REG_SAMPLE_PERIOD: ts_q       <= cfg_data_i[30:0];
          REG_OUT_LOW:       out_low_q  <= cfg_data_i;
          REG_OUT_HIGH:      out_high_q <= cfg_data_i;
          REG_WINDUP_MARGIN: margin_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      // a finishing program refills the result register, even as the old one leaves
      if (step_go && uc_w.done)             out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      if (in_xfer) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
      end else if (step_go) begin
        if (uc_w.done) begin
          busy_q <= 1'b0;
        end else if (uc_w.br_rst && op_q) begin
          pc_q <= uc_w.br_tgt;
        end else begin
          pc_q <= pc_q + 1'b1;
        end
        case (uc_w.dst)
          D_INTEG: integ_q <= alu_res;
          D_HELD:  held_q  <= alu_res;
          default: ;
        endcase
      end
    end
  end

  // datapath scratch, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= operation_i;
      meas_q   <= measured_i;
      target_q <= target_i;
      preset_q <= preset_output_i;
    end
    if (step_go) begin
      if (uc_w.mul_en) prod_q <= mul_res;
      if (uc_w.done)   drive_q <= held_q;
      case (uc_w.dst)
        D_ERR:   err_q <= alu_res;
        D_WLO:   wlo_q <= alu_res;
        D_WHI:   whi_q <= alu_res;
        D_T:     t_q   <= alu_res;
        D_P:     p_q   <= alu_res;
        D_I:     i_q   <= alu_res;
        default: ;
      endcase
    end
  end

  // the sequencer never runs past the end of the control store
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= UcLast)
    else $error("sequencer address out of program");

  // a new transfer always starts the program at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q && pc_q == '0)
    else $error("item did not start at step zero");

  // a result appears only from a completed last step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_go && uc_w.done))
    else $error("result without a finished program");

  // last step waits while an earlier result is still held
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && uc_w.done && out_valid_q && out_stall_i |=> busy_q && $stable(pc_q))
    else $error("result register overwritten");

endmodule

// ===== tb/sv/pics_tb_pkg.sv =====
`timescale 1ns / 100ps
package pics_tb_pkg;
  import pics_pkg::*;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  localparam longint QOne   = 65536;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  // cap on printed mismatch lines
  localparam int MaxReports = 100;

  class drive_scoreboard;
    // tuning copy
    longint kp, ki, ts, out_lo, out_hi, margin;
    // controller state
    longint integ_acc, last_drive;
    logic [31:0] pending_drive[$];
    int errors;
    int checked;

    function new();
      clear();
    endfunction

    function void clear();
      kp         = QOne;
      ki         = 0;
      ts         = QOne;
      out_lo     = -QOne;
      out_hi     = QOne;
      margin     = 0;
      integ_acc  = 0;
      last_drive = 0;
      errors     = 0;
      checked    = 0;
      pending_drive.delete();
    endfunction

    function longint sat_s32(longint v);
      if (v > S32Max) return S32Max;
      if (v < S32Min) return S32Min;
      return v;
    endfunction

    // Q16.16 product, truncated toward zero
    function longint qmul(longint a, longint b);
      return sat_s32((a * b) / QOne);
    endfunction

    // raise first, then lower: inverted bounds give the upper one
    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] data);
      case (idx)
        REG_PROP_GAIN:     kp = $signed(data);
        REG_INTEG_GAIN:    ki = $signed(data);
        REG_SAMPLE_PERIOD: ts = {33'b0, data[30:0]};
        REG_OUT_LOW:       out_lo = $signed(data);
        REG_OUT_HIGH:      out_hi = $signed(data);
        REG_WINDUP_MARGIN: margin = {33'b0, data[30:0]};
        default: ;
      endcase
    endfunction

    function void take_sample(logic op, logic [31:0] meas, logic [31:0] tgt,
                              logic [31:0] preset);
      longint err, p_term, i_term, wide_lo, wide_hi, sum, pre;
      err    = sat_s32(longint'($signed(tgt)) - longint'($signed(meas)));
      p_term = clip(qmul(err, kp), out_lo, out_hi);
      i_term = qmul(qmul(err, ki), ts);
      if (op == OP_RESET) begin
        last_drive = $signed(preset);
        integ_acc  = sat_s32(sat_s32(last_drive - i_term) - p_term);
      end else begin
        wide_lo    = sat_s32(out_lo - margin);
        wide_hi    = sat_s32(out_hi + margin);
        sum        = sat_s32(sat_s32(p_term + i_term) + integ_acc);
        pre        = clip(sum, wide_lo, wide_hi);
        last_drive = clip(pre, out_lo, out_hi);
        integ_acc  = sat_s32(pre - p_term);
      end
      pending_drive.push_back(32'(last_drive));
    endfunction

    function void check_drive(logic [31:0] actual);
      logic [31:0] want;
      if (pending_drive.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: drive %h arrived with no sample pending", $time, actual);
        return;
      end
      want = pending_drive.pop_front();
      checked++;
      if (actual !== want) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: drive mismatch, expected %h (%0d) got %h (%0d)",
                   $time, want, $signed(want), actual, $signed(actual));
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/pi_controller_saturated_tb.sv =====
`timescale 1ns / 100ps
module pi_controller_saturated_tb;
  import pics_pkg::*;
  import pics_tb_pkg::*;

  localparam logic [31:0] Q1   = 32'h0001_0000;
  localparam logic [31:0] MaxW = 32'h7fff_ffff;
  localparam logic [31:0] MinW = 32'h8000_0000;

  // receiver hold-off length and the no-transfer watchdog limit (cycles)
  localparam int HoldCycles = 300;
  localparam int StuckLimit = 5000;
  // settle time after the last result
  localparam int SettleCycles = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_UPDATE;
  logic [31:0] measured_i = '0;
  logic [31:0] target_i = '0;
  logic [31:0] preset_output_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] drive_o;

  drive_scoreboard sb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int samples = 0;
  int reset_samples = 0;
  int tuning_loads = 0;

  pi_controller_saturated uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .measured_i      (measured_i),
    .target_i        (target_i),
    .preset_output_i (preset_output_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_o         (drive_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall per cycle, or a long hold-off when one is requested.
  // During a hold-off the output register stays full, the sequencer parks on its
  // last step and the input side has to stall.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checking and the watchdog. Sampled at the edge, so both see the
  // values that the transfer itself used.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_drive(drive_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Mostly small Q16.16 values (about +/-16.0), some full-range words and the
  // corner words of the 32-bit range.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(7))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return MinW;
          1: return MaxW;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
      default: return $urandom_range(32'h20_0000) - 32'h10_0000;
    endcase
  endfunction

  // One controller sample. Random idle cycles come first; valid stays up from
  // one transfer to the next when no gap is drawn.
  task automatic send_sample(input logic op, input logic [31:0] meas,
                             input logic [31:0] tgt, input logic [31:0] preset);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    measured_i      <= meas;
    target_i        <= tgt;
    preset_output_i <= preset;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // transfer happened at this edge
    sb.take_sample(op, meas, tgt, preset);
    samples++;
    if (op == OP_RESET) reset_samples++;
  endtask

  // Stop offering and wait until every predicted drive has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_tuning(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] ts, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [31:0] margin);
    cfg_write(REG_PROP_GAIN, kp);
    cfg_write(REG_INTEG_GAIN, ki);
    cfg_write(REG_SAMPLE_PERIOD, ts);
    cfg_write(REG_OUT_LOW, lo);
    cfg_write(REG_OUT_HIGH, hi);
    cfg_write(REG_WINDUP_MARGIN, margin);
    cfg_we_i <= 1'b0;
    tuning_loads++;
  endtask

  task automatic load_random_tuning();
    logic [31:0] kp, ki, ts, margin, a, b, lo, hi;
    kp     = ($urandom_range(3) == 0) ? rand_q() : $urandom_range(32'h4_0000);
    ki     = ($urandom_range(3) == 0) ? rand_q() : $urandom_range(32'h4_0000);
    // bit 31 of the unsigned registers is don't-care; full words exercise that
    ts     = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h2_0000);
    margin = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h4_0000);
    a      = rand_q();
    b      = rand_q();
    // usually ordered bounds; now and then whatever order falls out
    if ($urandom_range(7) == 0 || $signed(a) <= $signed(b)) begin
      lo = a;
      hi = b;
    end else begin
      lo = b;
      hi = a;
    end
    load_tuning(kp, ki, ts, lo, hi, margin);
  endtask

  // Closed loop: the measured value follows the last drive plus a little noise,
  // the target moves now and then, with occasional bumpless resets and junk words.
  task automatic run_loop(input int n_items);
    logic [31:0] tgt, meas;
    logic        op;
    tgt = rand_q();
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(9) == 0) tgt = rand_q();
      meas = 32'(sb.last_drive) + $urandom_range(32'h2000) - 32'h1000;
      if ($urandom_range(9) == 0) meas = $urandom;
      if ($urandom_range(15) == 0) tgt = $urandom;
      op = ($urandom_range(11) == 0) ? OP_RESET : OP_UPDATE;
      send_sample(op, meas, tgt, rand_q());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset tuning: kp 1.0, ki 0, clamps +/-1.0, no margin.
    send_sample(OP_UPDATE, 32'h0, 32'h0, 32'h0);
    send_sample(OP_UPDATE, MinW, MaxW, 32'h0);       // error saturates high
    send_sample(OP_UPDATE, MaxW, MinW, MaxW);        // error saturates low
    send_sample(OP_UPDATE, 32'h0000_8000, 32'h0, 32'h1234_5678); // preset unused
    send_sample(OP_RESET, 32'h0, Q1, MaxW);
    send_sample(OP_UPDATE, 32'h0, Q1, MinW);
    send_sample(OP_RESET, MaxW, MinW, MinW);
    send_sample(OP_RESET, 32'h0001_8000, 32'hffff_0000, 32'h0000_4000);
    wait_idle();

    // Moderate gains and headroom: bumpless start, windup against the clamp,
    // then the error turns around.
    load_tuning(32'h0002_0000, 32'h0000_8000, 32'h0000_0ccd, 32'hfffb_0000,
                32'h0005_0000, Q1);
    send_sample(OP_RESET, Q1, 32'h0001_8000, 32'h0002_0000);
    send_sample(OP_UPDATE, Q1, 32'h0001_8000, 32'h0);
    repeat (4) send_sample(OP_UPDATE, 32'h0, 32'h0003_0000, 32'h0);
    send_sample(OP_UPDATE, 32'h0003_0000, 32'h0, 32'h0);
    wait_idle();

    // Extreme tuning: widened bounds saturate, products saturate.
    load_tuning(MinW, MaxW, 32'hffff_ffff, MinW, MaxW, MaxW);
    send_sample(OP_UPDATE, MinW, MaxW, 32'h0);
    send_sample(OP_UPDATE, MaxW, MinW, 32'h0);
    send_sample(OP_RESET, 32'h0, Q1, MinW);
    send_sample(OP_UPDATE, 32'h0, Q1, 32'h0);
    wait_idle();

    // Inverted clamps: every clamp lands on the upper bound; zero period.
    load_tuning(MaxW, MinW, 32'h0, 32'h0003_0000, 32'hfffd_0000, 32'h0);
    send_sample(OP_UPDATE, 32'h0, 32'h0002_0000, 32'h0);
    send_sample(OP_RESET, 32'h0002_0000, 32'h0, 32'h0001_0000);
    send_sample(OP_UPDATE, 32'hfff0_0000, 32'h0010_0000, 32'h0);

    // Random part in three idle regimes; each block of samples runs under fresh
    // tuning loaded while idle, and one block per regime starts under a hold-off.
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < 8; c++) begin
        wait_idle();
        load_random_tuning();
        if (c == 3) hold_request = 1'b1;
        run_loop(48);
      end
    end

    wait_idle();
    $display("Ran %0d controller samples (%0d reset items) under %0d tuning loads,",
             samples, reset_samples, tuning_loads);
    $display("with and without handshake idling and one long output hold-off per regime;"
             , " %0d drive values checked.", sb.checked);
    if (sb.errors == 0 && sb.pending_drive.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
